// File: rtl/rtc_pkg.sv
// ----------------------------------------------------------------------------
// rtc_pkg
// Shared types, codes and digit helpers of the radix text converter.
// ----------------------------------------------------------------------------
package rtc_pkg;

	// Radix selector codes of the configuration registers.
	localparam logic [1:0] RADIX_BIN = 2'd0;
	localparam logic [1:0] RADIX_OCT = 2'd1;
	localparam logic [1:0] RADIX_DEC = 2'd2;
	localparam logic [1:0] RADIX_HEX = 2'd3;

	// Error codes carried with a result.
	localparam logic [1:0] ERR_NONE  = 2'd0;
	localparam logic [1:0] ERR_DIGIT = 2'd1;
	localparam logic [1:0] ERR_RANGE = 2'd2;

	localparam logic [7:0] CHAR_ZERO    = 8'h30;
	localparam logic [7:0] CHAR_NINE    = 8'h39;
	localparam logic [7:0] CHAR_UPPER_A = 8'h41;
	localparam logic [7:0] CHAR_UPPER_F = 8'h46;
	localparam logic [7:0] CHAR_LOWER_A = 8'h61;
	localparam logic [7:0] CHAR_LOWER_F = 8'h66;
	localparam logic [4:0] DIGIT_NONE   = 5'd16;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_DABBLE,
		ST_EMIT,
		ST_FAULT
	} rtc_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic acc_step;
		logic load_pow2;
		logic load_dec;
		logic dabble;
		logic shift_digit;
		logic emit_digit;
		logic emit_last;
		logic emit_fault;
		logic clear_num;
	} rtc_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic err_nz;
		logic digit_zero;
		logic out_free;
	} rtc_status_t;

	// Value of an ASCII digit character, or DIGIT_NONE when it is no digit.
	function automatic logic [4:0] digit_value(input logic [7:0] c);
		logic [4:0] d;
		d = DIGIT_NONE;
		if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
			d = 5'(c - CHAR_ZERO);
		end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) begin
			d = 5'(c - CHAR_UPPER_A + 8'd10);
		end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F) begin
			d = 5'(c - CHAR_LOWER_A + 8'd10);
		end
		return d;
	endfunction

	function automatic logic [4:0] radix_value(input logic [1:0] code);
		logic [4:0] r;
		unique case (code)
			RADIX_BIN: r = 5'd2;
			RADIX_OCT: r = 5'd8;
			RADIX_DEC: r = 5'd10;
			RADIX_HEX: r = 5'd16;
		endcase
		return r;
	endfunction

	// ASCII character of a digit value, uppercase letters for ten and above.
	function automatic logic [7:0] digit_ascii(input logic [3:0] d);
		logic [7:0] c;
		if (d < 4'd10) begin
			c = CHAR_ZERO + 8'(d);
		end else begin
			c = CHAR_UPPER_A + 8'(d - 4'd10);
		end
		return c;
	endfunction

endpackage

// File: rtl/rtc_ctrl.sv
// ----------------------------------------------------------------------------
// rtc_ctrl
// Sequencer of the radix text converter: accepts characters, runs the
// binary to decimal pass and steps the digit emission.
// ----------------------------------------------------------------------------
module rtc_ctrl #(
	parameter int VALUE_BITS = 31
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_last,
	input  logic [1:0]          target_radix,
	input  rtc_pkg::rtc_status_t status,
	output logic                in_ready,
	output rtc_pkg::rtc_cmd_t    cmd
);
	import rtc_pkg::*;

	localparam int CW         = $clog2(VALUE_BITS + 1);
	localparam int OCT_DIGITS = (VALUE_BITS + 2) / 3;
	localparam int HEX_DIGITS = (VALUE_BITS + 3) / 4;
	localparam int DEC_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;

	rtc_state_t   state_q, state_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic         started_q, started_d;
	logic         cnt_one;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			started_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			cnt_q     <= cnt_d;
			started_q <= started_d;
		end
	end

	assign cnt_one = (cnt_q == CW'(1));

	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		started_d = started_q;
		cmd       = '0;
		in_ready  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.acc_step = 1'b1;
					if (in_last) begin
						state_d = ST_LOAD;
					end
				end
			end
			ST_LOAD: begin
				started_d = 1'b0;
				if (status.err_nz) begin
					state_d = ST_FAULT;
				end else if (target_radix == RADIX_DEC) begin
					cmd.load_dec = 1'b1;
					cnt_d        = CW'(VALUE_BITS);
					state_d      = ST_DABBLE;
				end else begin
					cmd.load_pow2 = 1'b1;
					state_d       = ST_EMIT;
					unique case (target_radix)
						RADIX_BIN: cnt_d = CW'(VALUE_BITS);
						RADIX_OCT: cnt_d = CW'(OCT_DIGITS);
						RADIX_DEC: cnt_d = CW'(DEC_DIGITS);
						RADIX_HEX: cnt_d = CW'(HEX_DIGITS);
					endcase
				end
			end
			ST_DABBLE: begin
				cmd.dabble = 1'b1;
				cnt_d      = cnt_q - CW'(1);
				if (cnt_one) begin
					cnt_d   = CW'(DEC_DIGITS);
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (status.digit_zero && !started_q && !cnt_one) begin
					// Leading zero: drop it without a result.
					cmd.shift_digit = 1'b1;
					cnt_d           = cnt_q - CW'(1);
				end else if (status.out_free) begin
					cmd.emit_digit = 1'b1;
					cmd.emit_last  = cnt_one;
					started_d      = 1'b1;
					cnt_d          = cnt_q - CW'(1);
					if (cnt_one) begin
						cmd.clear_num = 1'b1;
						state_d       = ST_IDLE;
					end
				end
			end
			ST_FAULT: begin
				if (status.out_free) begin
					cmd.emit_fault = 1'b1;
					cmd.clear_num  = 1'b1;
					state_d        = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// File: rtl/rtc_dp.sv
// ----------------------------------------------------------------------------
// rtc_dp
// Datapath of the radix text converter: value accumulator, error latch,
// digit work register with the binary to decimal adjuster, output register.
// ----------------------------------------------------------------------------
module rtc_dp #(
	parameter int VALUE_BITS = 31
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rtc_pkg::rtc_cmd_t     cmd,
	input  logic [7:0]           char_code,
	input  logic [1:0]           source_radix,
	input  logic [1:0]           target_radix,
	input  logic                 out_ready,
	output rtc_pkg::rtc_status_t  status,
	output logic                 out_valid,
	output logic [7:0]           digit_char,
	output logic                 last_digit,
	output logic [1:0]           error_code
);
	import rtc_pkg::*;

	localparam int VB         = VALUE_BITS;
	localparam int EW         = VB + 5;
	localparam int OCT_DIGITS = (VB + 2) / 3;
	localparam int HEX_DIGITS = (VB + 3) / 4;
	localparam int DEC_DIGITS = (VB * 30103) / 100000 + 1;
	localparam int DEC_BITS   = 4 * DEC_DIGITS;
	localparam int W_A        = (VB > 3 * OCT_DIGITS) ? VB : 3 * OCT_DIGITS;
	localparam int W_B        = (4 * HEX_DIGITS > DEC_BITS) ? 4 * HEX_DIGITS : DEC_BITS;
	localparam int WB         = (W_A > W_B) ? W_A : W_B;
	localparam int PAD_BIN    = WB - VB;
	localparam int PAD_OCT    = WB - 3 * OCT_DIGITS;
	localparam int PAD_HEX    = WB - 4 * HEX_DIGITS;

	logic [VB-1:0]       acc_q;
	logic [1:0]          err_q;
	logic [WB-1:0]       work_q;
	logic                out_valid_q;
	logic [7:0]          out_char_q;
	logic                out_last_q;
	logic [1:0]          out_err_q;

	logic [4:0]          in_digit;
	logic                bad_digit;
	logic [EW-1:0]       acc_ext;
	logic [EW-1:0]       prod;
	logic [EW-1:0]       sum;
	logic                overflow;
	logic [DEC_BITS-1:0] bcd;
	logic [DEC_BITS-1:0] bcd_adj;
	logic [3:0]          nib;
	logic [WB-1:0]       work_dabble;
	logic [3:0]          top4;
	logic [3:0]          top_digit;
	logic [WB-1:0]       work_shift;
	logic [WB-1:0]       work_load;

	// Next value of the accumulator: value * radix + digit.
	always_comb begin
		in_digit  = digit_value(char_code);
		bad_digit = (in_digit >= radix_value(source_radix));
		acc_ext   = EW'(acc_q);
		unique case (source_radix)
			RADIX_BIN: prod = acc_ext << 1;
			RADIX_OCT: prod = acc_ext << 3;
			RADIX_DEC: prod = (acc_ext << 3) + (acc_ext << 1);
			RADIX_HEX: prod = acc_ext << 4;
		endcase
		sum      = prod + EW'(in_digit);
		overflow = |sum[EW-1:VB];
	end

	// One step of shift-and-add-3 on the decimal digits at the top of work_q.
	always_comb begin
		bcd     = work_q[WB-1 -: DEC_BITS];
		bcd_adj = bcd;
		nib     = '0;
		for (int i = 0; i < DEC_DIGITS; i++) begin
			nib = bcd[i*4 +: 4];
			bcd_adj[i*4 +: 4] = (nib >= 4'd5) ? nib + 4'd3 : nib;
		end
		work_dabble = work_q;
		work_dabble[WB-1 -: DEC_BITS] = {bcd_adj[DEC_BITS-2:0], acc_q[VB-1]};
	end

	// Digit at the top of work_q and the shift past it.
	always_comb begin
		top4 = work_q[WB-1 -: 4];
		unique case (target_radix)
			RADIX_BIN: begin
				top_digit  = {3'b000, top4[3]};
				work_shift = work_q << 1;
			end
			RADIX_OCT: begin
				top_digit  = {1'b0, top4[3:1]};
				work_shift = work_q << 3;
			end
			RADIX_DEC, RADIX_HEX: begin
				top_digit  = top4;
				work_shift = work_q << 4;
			end
		endcase
		unique case (target_radix)
			RADIX_BIN: work_load = WB'(acc_q) << PAD_BIN;
			RADIX_OCT: work_load = WB'(acc_q) << PAD_OCT;
			RADIX_DEC: work_load = '0;
			RADIX_HEX: work_load = WB'(acc_q) << PAD_HEX;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			err_q <= ERR_NONE;
		end else begin
			if (cmd.clear_num) begin
				acc_q <= '0;
				err_q <= ERR_NONE;
			end else if (cmd.dabble) begin
				acc_q <= acc_q << 1;
			end else if (cmd.acc_step && err_q == ERR_NONE) begin
				if (bad_digit) begin
					err_q <= ERR_DIGIT;
				end else if (overflow) begin
					err_q <= ERR_RANGE;
				end else begin
					acc_q <= sum[VB-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_pow2) begin
			work_q <= work_load;
		end else if (cmd.load_dec) begin
			work_q <= '0;
		end else if (cmd.dabble) begin
			work_q <= work_dabble;
		end else if (cmd.shift_digit || cmd.emit_digit) begin
			work_q <= work_shift;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_digit || cmd.emit_fault) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_digit) begin
			out_char_q <= digit_ascii(top_digit);
			out_last_q <= cmd.emit_last;
			out_err_q  <= ERR_NONE;
		end else if (cmd.emit_fault) begin
			out_char_q <= '0;
			out_last_q <= 1'b1;
			out_err_q  <= err_q;
		end
	end

	assign status.err_nz     = (err_q != ERR_NONE);
	assign status.digit_zero = (top_digit == 4'd0);
	assign status.out_free   = !out_valid_q || out_ready;

	assign out_valid  = out_valid_q;
	assign digit_char = out_char_q;
	assign last_digit = out_last_q;
	assign error_code = out_err_q;

	a_emit_needs_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_digit || cmd.emit_fault) |-> status.out_free)
		else $error("result produced while the output register is still full");

	a_emit_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.emit_digit && cmd.emit_fault))
		else $error("digit and fault result in the same cycle");

	a_fault_flagged: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_fault |=> (out_valid_q && out_last_q && out_err_q != ERR_NONE))
		else $error("fault result without an error code");

	a_err_code_legal: assert property (@(posedge clk) disable iff (!arst_n)
		err_q != 2'd3)
		else $error("error latch holds an undefined code");

	a_digit_ascii: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_digit |=> ((out_char_q >= CHAR_ZERO && out_char_q <= CHAR_NINE)
			|| (out_char_q >= CHAR_UPPER_A && out_char_q <= CHAR_UPPER_F)))
		else $error("emitted digit is not an ASCII digit");

endmodule

// File: rtl/radix_text_converter_unit.sv
// ----------------------------------------------------------------------------
// radix_text_converter_unit
// ASCII number converter between binary, octal, decimal and hexadecimal.
// ----------------------------------------------------------------------------
// The block takes the ASCII digits of one number, one character per request
// on the input stream, in the source radix (letters in either case), and
// accumulates its value in VALUE_BITS bits. Every character that is not the
// last one is taken while the block stays idle, so a text stream flows at one
// character per clock. On the character marked with tlast the input stalls
// while the value is written out, most significant digit first, in the target
// radix with uppercase hexadecimal letters; the final digit carries tlast.
// After the last character the load state sets up the digit register;
// decimal output then runs a shift-and-add-3 pass that turns the value into
// decimal digits. The emission then drops each leading zero digit and
// delivers the other digits, stalling while the output register is full and
// the output side holds tready low.
// An invalid character or a value beyond 2^VALUE_BITS-1 gives instead a
// single result with data byte 0, tlast set and the error code in tuser; the
// first error of a number wins. Zero is written as one "0". The radix
// registers are to be written through the APB port only while no number is
// in progress; the block itself does not enforce this, the user must.
// The output register lets the next number's characters be accepted while the
// last digit still waits to be taken.
// ----------------------------------------------------------------------------
module radix_text_converter_unit #(
	parameter int VALUE_BITS = 31
) (
	input  logic        clk,
	input  logic        arst_n,
	// Input stream.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] char_code
	input  logic        s_tlast,   // last_char
	// Output stream.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] digit_char
	output logic        m_tlast,   // last_digit
	output logic [1:0]  m_tuser,   // [1:0] error_code
	// Configuration port.
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import rtc_pkg::*;

	// Register map: source_radix at byte address 0, target_radix at 4.
	localparam logic REG_SOURCE = 1'b0;
	localparam logic REG_TARGET = 1'b1;

	logic [1:0]  source_radix_q;
	logic [1:0]  target_radix_q;
	logic        cfg_write;
	rtc_cmd_t    cmd;
	rtc_status_t status;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	// The radix registers reset to decimal in and hexadecimal out.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_radix_q <= RADIX_DEC;
			target_radix_q <= RADIX_HEX;
		end else if (cfg_write) begin
			unique case (paddr[2])
				REG_SOURCE: source_radix_q <= pwdata[1:0];
				REG_TARGET: target_radix_q <= pwdata[1:0];
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_SOURCE: prdata = {30'd0, source_radix_q};
			REG_TARGET: prdata = {30'd0, target_radix_q};
		endcase
	end

	// The controller sequences the number; the datapath holds every value.
	rtc_ctrl #(
		.VALUE_BITS (VALUE_BITS)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_tvalid),
		.in_last      (s_tlast),
		.target_radix (target_radix_q),
		.status       (status),
		.in_ready     (s_tready),
		.cmd          (cmd)
	);

	rtc_dp #(
		.VALUE_BITS (VALUE_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.char_code    (s_tdata),
		.source_radix (source_radix_q),
		.target_radix (target_radix_q),
		.out_ready    (m_tready),
		.status       (status),
		.out_valid    (m_tvalid),
		.digit_char   (m_tdata),
		.last_digit   (m_tlast),
		.error_code   (m_tuser)
	);

endmodule

// File: bench/radix_text_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// radix_text_checker
// Watches both streams and the register port of the radix text converter.
// Every character accepted on the input updates a private copy of the number
// being built. The last character of a number queues the expected output
// digits. Each digit taken on the output is compared with the oldest entry.
// ----------------------------------------------------------------------------
module radix_text_checker #(
	parameter int         VALUE_BITS  = 31,
	parameter logic [2:0] SOURCE_ADDR = 3'd0,
	parameter logic [2:0] TARGET_ADDR = 3'd4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] char_code
	input  logic        s_tlast,   // last_char
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [7:0]  m_tdata,   // [7:0] digit_char
	input  logic        m_tlast,   // last_digit
	input  logic [1:0]  m_tuser,   // [1:0] error_code
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int          fail_count,
	output int          pending,
	output int          digits_checked
);
	import rtc_pkg::*;

	localparam longint unsigned VALUE_LIMIT = (64'd1 << VALUE_BITS) - 64'd1;

	typedef struct packed {
		logic [7:0] digit;
		logic       last;
		logic [1:0] code;
	} digit_result_t;

	digit_result_t   expected_digits [$];
	logic [1:0]      src_code;
	logic [1:0]      tgt_code;
	longint unsigned number_value;
	logic [1:0]      number_error;

	function automatic longint unsigned base_of(input logic [1:0] code);
		longint unsigned b;
		case (code)
			RADIX_BIN: b = 2;
			RADIX_OCT: b = 8;
			RADIX_DEC: b = 10;
			default:   b = 16;
		endcase
		return b;
	endfunction

	// Appends one expected result behind the ones already owed.
	function automatic void queue_result(input digit_result_t res);
		expected_digits.insert(expected_digits.size(), res);
	endfunction

	task automatic report_mismatch(input string what);
		$display("[%0t] mismatch: %s", $time, what);
		fail_count++;
	endtask

	// Folds one character into the number; the last one queues the digits.
	task automatic predict_character(input logic [7:0] c, input logic last);
		longint unsigned r;
		longint unsigned d;
		longint unsigned t;
		longint unsigned v;
		logic [7:0]      ascii [$];
		digit_result_t   res;
		r = base_of(src_code);
		if (number_error == ERR_NONE) begin
			if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
				d = c - CHAR_ZERO;
			end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) begin
				d = c - CHAR_UPPER_A + 10;
			end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F) begin
				d = c - CHAR_LOWER_A + 10;
			end else begin
				d = 16;
			end
			if (d >= r) begin
				number_error = ERR_DIGIT;
			end else if (number_value > (VALUE_LIMIT - d) / r) begin
				number_error = ERR_RANGE;
			end else begin
				number_value = number_value * r + d;
			end
		end
		if (last) begin
			if (number_error != ERR_NONE) begin
				res.digit = 8'd0;
				res.last = 1'b1;
				res.code = number_error;
				queue_result(res);
			end else begin
				t = base_of(tgt_code);
				v = number_value;
				do begin
					d = v % t;
					ascii.push_front(d < 10 ? CHAR_ZERO + 8'(d) : CHAR_UPPER_A + 8'(d - 10));
					v = v / t;
				end while (v != 0);
				foreach (ascii[k]) begin
					res.digit = ascii[k];
					res.last = (k == ascii.size() - 1);
					res.code = ERR_NONE;
					queue_result(res);
				end
			end
			number_value = 0;
			number_error = ERR_NONE;
		end
	endtask

	task automatic check_digit();
		digit_result_t want;
		digits_checked++;
		if (expected_digits.size() == 0) begin
			report_mismatch($sformatf("unexpected result %02h last %0d code %0d",
				m_tdata, m_tlast, m_tuser));
		end else begin
			want = expected_digits.pop_front();
			if (m_tdata != want.digit)
				report_mismatch($sformatf("digit %02h, wanted %02h", m_tdata, want.digit));
			if (m_tlast != want.last)
				report_mismatch($sformatf("last %0d, wanted %0d", m_tlast, want.last));
			if (m_tuser != want.code)
				report_mismatch($sformatf("error code %0d, wanted %0d", m_tuser, want.code));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_code = RADIX_DEC;
			tgt_code = RADIX_HEX;
			number_value = 0;
			number_error = ERR_NONE;
			expected_digits.delete();
			fail_count = 0;
			digits_checked = 0;
			pending <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr == SOURCE_ADDR) src_code = pwdata[1:0];
				else if (paddr == TARGET_ADDR) tgt_code = pwdata[1:0];
			end
			if (s_tvalid && s_tready) predict_character(s_tdata, s_tlast);
			if (m_tvalid && m_tready) check_digit();
			pending <= expected_digits.size();
		end
	end

endmodule

// File: bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the radix text converter.
// A short directed run covers zero, the largest value, overflow, invalid
// characters and equal radices; random numbers follow under a series of
// radix settings, with random gaps on both streams. The checker beside the
// block predicts and compares every output digit.
// ----------------------------------------------------------------------------
module testbench;
	import rtc_pkg::*;

	// Byte addresses of the two radix registers.
	localparam logic [2:0] SOURCE_ADDR = 3'd0;
	localparam logic [2:0] TARGET_ADDR = 3'd4;
	// Characters of random stimulus to send, and of one radix setting.
	localparam int RANDOM_CHARS = 440;
	localparam int PHASE_CHARS  = 50;

	logic        clk;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = 8'd0;
	logic        s_tlast  = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic        m_tlast;
	logic [1:0]  m_tuser;
	logic        psel     = 1'b0;
	logic        penable  = 1'b0;
	logic        pwrite   = 1'b0;
	logic [2:0]  paddr    = 3'd0;
	logic [31:0] pwdata   = 32'd0;
	logic [31:0] prdata;
	logic        pready;

	int fail_count;
	int pending;
	int digits_checked;

	// When set, neither side inserts any idle cycles.
	bit         steady = 1'b0;
	logic [7:0] text [$];
	int         chars_sent;
	int         numbers_sent;
	int         settings_used;

	radix_text_converter_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	radix_text_checker #(
		.SOURCE_ADDR (SOURCE_ADDR),
		.TARGET_ADDR (TARGET_ADDR)
	) u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// A generous ceiling: even the slowest legal run finishes well inside it.
	initial begin
		#20_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	function automatic int draw_wait();
		return steady ? 0 : $urandom_range(0, 5);
	endfunction

	// Adds one character to the end of the text being built.
	function automatic void append_char(input logic [7:0] c);
		text.insert(text.size(), c);
	endfunction

	// The output side takes each digit after a random stall of its own.
	initial begin
		int stall;
		forever begin
			stall = draw_wait();
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	// Offers one character after a random gap and holds it until it is taken.
	// tvalid is only lowered when a gap follows, so back-to-back requests keep
	// it high without a second assignment in the same step.
	task automatic send_char(input logic [7:0] c, input logic last);
		int gap;
		gap = draw_wait();
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= c;
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
		chars_sent++;
	endtask

	task automatic send_text();
		foreach (text[i]) send_char(text[i], i == text.size() - 1);
		numbers_sent++;
	endtask

	task automatic send_string(input string s);
		text.delete();
		for (int i = 0; i < s.len(); i++) append_char(s[i]);
		send_text();
	endtask

	// Setup and access cycle of one write; the port is left selected so that
	// a following write can start its setup cycle straight away.
	task automatic write_reg(input logic [2:0] addr, input logic [1:0] code);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= 32'(code);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
	endtask

	// Registers change only once the block has delivered everything it owes.
	// The first edge lets the checker count the request just accepted; the
	// margin afterwards covers the output register draining.
	task automatic configure(input logic [1:0] src, input logic [1:0] tgt);
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (8) @(posedge clk);
		write_reg(SOURCE_ADDR, src);
		write_reg(TARGET_ADDR, tgt);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		settings_used++;
	endtask

	// Builds one number in the source radix. Most are well formed with a
	// random length, some run up to two digits past the safe width so that
	// overflow appears, a few have one character replaced by a random byte,
	// and the rest are pure noise.
	task automatic build_number(input logic [1:0] code);
		int base;
		int safe;
		int len;
		int roll;
		int d;
		text.delete();
		case (code)
			RADIX_BIN: begin
				base = 2;
				safe = 31;
			end
			RADIX_OCT: begin
				base = 8;
				safe = 10;
			end
			RADIX_DEC: begin
				base = 10;
				safe = 9;
			end
			default: begin
				base = 16;
				safe = 7;
			end
		endcase
		roll = $urandom_range(0, 99);
		if (roll >= 92) begin
			len = $urandom_range(1, 4);
			repeat (len) append_char(8'($urandom_range(0, 255)));
		end else begin
			if (roll < 55) len = $urandom_range(1, 4);
			else if (roll < 80) len = $urandom_range(1, safe);
			else len = $urandom_range(safe, safe + 2);
			repeat (len) begin
				d = $urandom_range(0, base - 1);
				if (d < 10) begin
					append_char(CHAR_ZERO + 8'(d));
				end else begin
					append_char(($urandom_range(0, 1) ? CHAR_UPPER_A : CHAR_LOWER_A)
						+ 8'(d - 10));
				end
			end
			if ($urandom_range(0, 19) == 0)
				text[$urandom_range(0, len - 1)] = 8'($urandom_range(0, 255));
		end
	endtask

	initial begin
		int         random_chars;
		int         phase_chars;
		int         phase;
		logic [1:0] src;
		logic [1:0] tgt;
		chars_sent = 0;
		numbers_sent = 0;
		settings_used = 1;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. With the reset radices, decimal in and hex out, zero
		// must come back as a single "0" and a letter is no decimal digit.
		send_string("0");
		send_string("a");
		// Hex into binary: the largest value gives the widest output, one
		// more and the value overflows; the extreme codes are no digits.
		configure(RADIX_HEX, RADIX_BIN);
		send_string("7FFFFFFF");
		send_string("80000000");
		send_char(8'hFF, 1'b1);
		send_char(8'h00, 1'b1);
		numbers_sent += 2;
		// A two in binary is invalid after a good first digit.
		configure(RADIX_BIN, RADIX_DEC);
		send_string("12");
		// Lowercase hex letters, and octal with leading zeros, which are dropped.
		configure(RADIX_HEX, RADIX_OCT);
		send_string("ff");
		configure(RADIX_OCT, RADIX_OCT);
		send_string("007");

		// Random part: the extreme settings first, then random ones. About
		// one setting in four runs with no idle cycles on either side.
		random_chars = 0;
		phase = 0;
		while (random_chars < RANDOM_CHARS) begin
			case (phase)
				0: begin
					src = RADIX_BIN;
					tgt = RADIX_BIN;
				end
				1: begin
					src = RADIX_HEX;
					tgt = RADIX_HEX;
				end
				2: begin
					src = RADIX_BIN;
					tgt = RADIX_HEX;
				end
				3: begin
					src = RADIX_HEX;
					tgt = RADIX_BIN;
				end
				default: begin
					src = 2'($urandom_range(0, 3));
					tgt = 2'($urandom_range(0, 3));
				end
			endcase
			configure(src, tgt);
			steady <= ($urandom_range(0, 3) == 0);
			phase_chars = 0;
			while (phase_chars < PHASE_CHARS && random_chars < RANDOM_CHARS) begin
				build_number(src);
				send_text();
				phase_chars += text.size();
				random_chars += text.size();
			end
			phase++;
		end

		// Drain: wait for every owed digit, then a margin for strays.
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (64) @(posedge clk);

		$display("Converted %0d numbers from %0d characters under %0d radix settings.",
			numbers_sent, chars_sent, settings_used);
		$display("Checked %0d output results, %0d mismatches.", digits_checked, fail_count);
		if (fail_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

// File: sim.f
rtl/rtc_pkg.sv
rtl/rtc_ctrl.sv
rtl/rtc_dp.sv
rtl/radix_text_converter_unit.sv
bench/radix_text_checker.sv
bench/testbench.sv
